@@ src/kdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlp_pkg: shared types and constants for the key debounce block
// Field widths, register indexes, reset values and the phase encoding.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  // Field widths
  localparam int KEY_LEVELS_W = 6;
  localparam int KEY_CODE_W   = 3;
  localparam int DEBOUNCE_W   = 8;
  localparam int LONG_PRESS_W = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 1'd1;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RST   = 8'd5;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RST = 16'd1000;

  // Tracking phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2
  } phase_e;

  typedef logic [KEY_CODE_W-1:0] key_code_t;

endpackage

@@ src/kdlp_out_skid.sv @@
// ----------------------------------------------------------------------------
// kdlp_out_skid: output register with one skid entry
// Holds a finished key code while the sink stalls and keeps the input side
// open until both entries are occupied.
// ----------------------------------------------------------------------------
module kdlp_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kdlp_pkg::key_code_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kdlp_pkg::key_code_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  kdlp_pkg::key_code_t out_data_q, out_data_d;
  kdlp_pkg::key_code_t skid_data_q, skid_data_d;
  logic                out_pop;

  assign out_pop = out_valid_q & ~out_stall_i;

  // Route a new item to the output register or the skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/key_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// key_debounce_long_press: key debounce with long-press detection
// The key code is loaded into the output register, or into its skid entry if
// the output register still holds a code, at the edge that accepts the tick
// showing the release. Throughput: one tick per cycle; the input stalls only
// when the output register and its skid entry are both full.
// Reset: phase idle, tracked key and hold count zero, debounce 5, long 1000.
// ----------------------------------------------------------------------------
module key_debounce_long_press #(
  parameter int NUM_KEYS        = 6,
  parameter int HOLD_COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tick channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kdlp_pkg::KEY_LEVELS_W-1:0]   key_levels_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kdlp_pkg::KEY_CODE_W-1:0]     key_code_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kdlp_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CmpW = (HOLD_COUNT_BITS > kdlp_pkg::LONG_PRESS_W) ?
                        HOLD_COUNT_BITS : kdlp_pkg::LONG_PRESS_W;

  logic [kdlp_pkg::DEBOUNCE_W-1:0]   debounce_q;
  logic [kdlp_pkg::LONG_PRESS_W-1:0] long_press_q;

  kdlp_pkg::phase_e         phase_q, phase_d;
  logic [KeyW-1:0]          tracked_q, tracked_d;
  logic [HOLD_COUNT_BITS-1:0] hold_q, hold_d, count_inc;

  logic [NUM_KEYS-1:0]      levels;
  logic                     in_accept;
  logic                     held;
  logic                     any_pressed;
  logic [KeyW-1:0]          first_key;
  logic                     debounce_done;
  logic                     is_long;
  logic                     res_valid;
  kdlp_pkg::key_code_t      res_code;
  logic                     skid_full;

  assign in_accept   = in_valid_i & ~in_stall_o;
  assign in_stall_o  = skid_full;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= kdlp_pkg::DEBOUNCE_RST;
      long_press_q <= kdlp_pkg::LONG_PRESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kdlp_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data_i[kdlp_pkg::DEBOUNCE_W-1:0];
        kdlp_pkg::CFG_LONG_PRESS: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Keys beyond the field read as pressed
  assign levels = NUM_KEYS'(key_levels_i);

  // Pick the first pressed key, lowest index wins
  always_comb begin
    first_key = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (!levels[k]) begin
        first_key = KeyW'(k);
      end
    end
  end

  assign any_pressed   = ~&levels;
  assign held          = ~levels[tracked_q];
  assign count_inc     = (&hold_q) ? hold_q : hold_q + 1'b1;
  assign debounce_done = CmpW'(count_inc) >= CmpW'(debounce_q);
  assign is_long       = (tracked_q == KeyW'(NUM_KEYS - 1)) &&
                         (CmpW'(count_inc) > CmpW'(long_press_q));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (in_accept) begin
      case (phase_q)
        kdlp_pkg::PH_DEBOUNCE: begin
          if (debounce_done) begin
            phase_d = held ? kdlp_pkg::PH_HOLD : kdlp_pkg::PH_IDLE;
          end
        end
        kdlp_pkg::PH_HOLD: begin
          if (!held) begin
            phase_d = kdlp_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = any_pressed ? kdlp_pkg::PH_DEBOUNCE : kdlp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Counter, tracked key and result
  always_comb begin
    hold_d    = hold_q;
    tracked_d = tracked_q;
    res_valid = 1'b0;
    res_code  = is_long ? kdlp_pkg::KEY_CODE_W'(NUM_KEYS)
                        : kdlp_pkg::KEY_CODE_W'(tracked_q);
    if (in_accept) begin
      case (phase_q)
        kdlp_pkg::PH_DEBOUNCE: begin
          hold_d = count_inc;
        end
        kdlp_pkg::PH_HOLD: begin
          hold_d    = count_inc;
          res_valid = ~held;
        end
        default: begin
          if (any_pressed) begin
            hold_d    = '0;
            tracked_d = first_key;
          end
        end
      endcase
    end
  end

  // Advance tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= kdlp_pkg::PH_IDLE;
      tracked_q <= '0;
      hold_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      tracked_q <= tracked_d;
      hold_q    <= hold_d;
    end
  end

  // Output register with skid entry
  kdlp_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res_code),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (key_code_o)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for key_debounce_long_press
// A short table of ticks covers reset values, every key code, cancel at the
// re-sample and long press. Random press sequences over several register
// settings follow. A table row that types a key code is checked against it;
// all other results against an in-house tracker of the debounce state.
// ----------------------------------------------------------------------------
module tb;

  localparam int KEY_COUNT  = 6;
  localparam int COUNT_BITS = 16;
  localparam int LAST_KEY   = KEY_COUNT - 1;
  localparam int MAX_SHOWN  = 10;
  localparam int MIN_TICKS  = 150;
  localparam int MIN_CODES  = 6;
  localparam logic [kdlp_pkg::KEY_LEVELS_W-1:0] ALL_UP = '1;

  // Key codes as seen on the result channel
  localparam kdlp_pkg::key_code_t KC_UP           = 3'd0;
  localparam kdlp_pkg::key_code_t KC_DOWN         = 3'd1;
  localparam kdlp_pkg::key_code_t KC_LEFT         = 3'd2;
  localparam kdlp_pkg::key_code_t KC_RIGHT        = 3'd3;
  localparam kdlp_pkg::key_code_t KC_LEFT_X       = 3'd4;
  localparam kdlp_pkg::key_code_t KC_RIGHT_X      = 3'd5;
  localparam kdlp_pkg::key_code_t KC_RIGHT_X_LONG = 3'd6;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_NONE,
    ROW_CODE
  } row_kind_e;

  typedef struct packed {
    logic [kdlp_pkg::KEY_LEVELS_W-1:0] levels;
    row_kind_e                         kind;
    kdlp_pkg::key_code_t               code;
  } stim_row_t;

  // First rows run with reset values, the rest with zero debounce, long 2
  localparam int RESET_ROWS = 6;
  localparam int ROW_COUNT  = 28;
  localparam stim_row_t DIRECTED [ROW_COUNT] = '{
    '{6'h3E, ROW_MODEL, KC_UP},
    '{6'h3E, ROW_MODEL, KC_UP},
    '{6'h3E, ROW_MODEL, KC_UP},
    '{6'h3E, ROW_MODEL, KC_UP},
    '{6'h3E, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_NONE,  KC_UP},
    '{6'h00, ROW_MODEL, KC_UP},
    '{6'h3E, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_CODE,  KC_UP},
    '{6'h3D, ROW_MODEL, KC_UP},
    '{6'h00, ROW_MODEL, KC_UP},
    '{6'h3E, ROW_CODE,  KC_DOWN},
    '{6'h33, ROW_MODEL, KC_UP},
    '{6'h3B, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_CODE,  KC_LEFT},
    '{6'h27, ROW_MODEL, KC_UP},
    '{6'h37, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_CODE,  KC_RIGHT},
    '{6'h0F, ROW_MODEL, KC_UP},
    '{6'h2F, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_CODE,  KC_LEFT_X},
    '{6'h1F, ROW_MODEL, KC_UP},
    '{6'h1F, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_CODE,  KC_RIGHT_X},
    '{6'h1F, ROW_MODEL, KC_UP},
    '{6'h1F, ROW_MODEL, KC_UP},
    '{6'h1F, ROW_MODEL, KC_UP},
    '{6'h3F, ROW_CODE,  KC_RIGHT_X_LONG}
  };

  // Register settings of the random phases; the last one is drawn at random
  localparam int PHASES      = 6;
  localparam int QUIET_PHASE = 2;
  localparam logic [kdlp_pkg::DEBOUNCE_W-1:0] PHASE_DEB [PHASES] = '{
    8'd1, 8'd3, 8'd2, 8'd24, 8'd12, 8'd7
  };
  localparam logic [kdlp_pkg::LONG_PRESS_W-1:0] PHASE_LONG [PHASES] = '{
    16'd1, 16'd25, 16'd6, 16'd36, 16'hFFFF, 16'd40
  };

  logic                              clk_i        = 1'b0;
  logic                              rst_ni       = 1'b0;
  logic                              in_valid_i   = 1'b0;
  logic                              in_stall_o;
  logic [kdlp_pkg::KEY_LEVELS_W-1:0] key_levels_i = '1;
  logic                              out_valid_o;
  logic                              out_stall_i  = 1'b0;
  kdlp_pkg::key_code_t               key_code_o;
  logic                              cfg_valid_i  = 1'b0;
  logic                              cfg_ready_o;
  logic [kdlp_pkg::CFG_INDEX_W-1:0]  cfg_index_i  = kdlp_pkg::CFG_DEBOUNCE;
  logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_data_i   = '0;

  // Tracker state and its copy of the registers
  kdlp_pkg::phase_e                  trk_phase;
  logic [2:0]                        trk_key;
  logic [COUNT_BITS-1:0]             trk_count;
  logic [kdlp_pkg::DEBOUNCE_W-1:0]   debounce_reg;
  logic [kdlp_pkg::LONG_PRESS_W-1:0] long_reg;

  kdlp_pkg::key_code_t code_q [$];
  int        errors         = 0;
  int        accepted_ticks = 0;
  int        emitted_codes  = 0;
  bit        gaps_on        = 1'b1;

  key_debounce_long_press #(
    .NUM_KEYS       (KEY_COUNT),
    .HOLD_COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_levels_i(key_levels_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_code_o  (key_code_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Advance the tracker by one tick; return 1 when a key code is due
  function automatic bit track_tick(input logic [kdlp_pkg::KEY_LEVELS_W-1:0] lv,
                                    output kdlp_pkg::key_code_t code);
    bit held;
    bit emit;
    bit found;
    held  = (lv[trk_key] == 1'b0);
    emit  = 1'b0;
    found = 1'b0;
    code  = KC_UP;
    case (trk_phase)
      kdlp_pkg::PH_DEBOUNCE: begin
        if (trk_count != '1) trk_count = trk_count + 1'b1;
        if (trk_count >= debounce_reg) begin
          trk_phase = held ? kdlp_pkg::PH_HOLD : kdlp_pkg::PH_IDLE;
        end
      end
      kdlp_pkg::PH_HOLD: begin
        if (trk_count != '1) trk_count = trk_count + 1'b1;
        if (!held) begin
          trk_phase = kdlp_pkg::PH_IDLE;
          emit      = 1'b1;
          if (trk_key == LAST_KEY && trk_count > long_reg) code = KC_RIGHT_X_LONG;
          else code = kdlp_pkg::key_code_t'(trk_key);
        end
      end
      default: begin
        // pick the first pressed key in priority order
        trk_phase = kdlp_pkg::PH_IDLE;
        for (int k = 0; k < KEY_COUNT; k++) begin
          if (!found && lv[k] == 1'b0) begin
            found     = 1'b1;
            trk_key   = 3'(k);
            trk_count = '0;
            trk_phase = kdlp_pkg::PH_DEBOUNCE;
          end
        end
      end
    endcase
    return emit;
  endfunction

  // Offer one tick item, wait for acceptance, queue what it causes
  task automatic send_tick(input logic [kdlp_pkg::KEY_LEVELS_W-1:0] lv,
                           input row_kind_e kind, input kdlp_pkg::key_code_t typed);
    kdlp_pkg::key_code_t code;
    bit                  emit;
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_levels_i <= lv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accepted_ticks++;
    emit = track_tick(lv, code);
    if (emit) emitted_codes++;
    case (kind)
      ROW_MODEL: if (emit) code_q.push_back(code);
      ROW_CODE:  code_q.push_back(typed);
      default: ;
    endcase
  endtask

  // Bring the block back to idle and drain all pending key codes
  task automatic settle();
    int waited;
    waited = 0;
    while (trk_phase != kdlp_pkg::PH_IDLE) send_tick(ALL_UP, ROW_MODEL, KC_UP);
    in_valid_i <= 1'b0;
    while (code_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (code_q.size() != 0) flag_error($sformatf("%0d key codes never came", code_q.size()));
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers back to back; upper data bits of debounce are junk
  task automatic set_config(input logic [kdlp_pkg::DEBOUNCE_W-1:0] deb,
                            input logic [kdlp_pkg::LONG_PRESS_W-1:0] lp);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= kdlp_pkg::CFG_DEBOUNCE;
    cfg_data_i  <= {8'($urandom), deb};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    debounce_reg = deb;
    cfg_index_i <= kdlp_pkg::CFG_LONG_PRESS;
    cfg_data_i  <= lp;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    long_reg = lp;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stalls at random while gaps are on
  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 14);
  end

  // Compare each accepted key code with the oldest one due
  always @(posedge clk_i) begin
    kdlp_pkg::key_code_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (code_q.size() == 0) begin
        flag_error($sformatf("key code %0d with none due", key_code_o));
      end else begin
        want = code_q.pop_front();
        if (key_code_o !== want)
          flag_error($sformatf("key code expected %0d, got %0d", want, key_code_o));
      end
    end
  end

  initial begin
    int                                ph_ticks;
    int                                ph_codes;
    int                                k;
    int                                hold_n;
    logic [kdlp_pkg::KEY_LEVELS_W-1:0] lv;
    trk_phase    = kdlp_pkg::PH_IDLE;
    trk_key      = '0;
    trk_count    = '0;
    debounce_reg = kdlp_pkg::DEBOUNCE_RST;
    long_reg     = kdlp_pkg::LONG_PRESS_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; zero debounce acts as one
    for (int i = 0; i < ROW_COUNT; i++) begin
      if (i == RESET_ROWS) begin
        settle();
        set_config(8'd0, 16'd2);
      end
      send_tick(DIRECTED[i].levels, DIRECTED[i].kind, DIRECTED[i].code);
    end

    // Random press sequences, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == PHASES - 1) set_config(8'($urandom_range(20, 1)), 16'($urandom_range(80, 1)));
      else set_config(PHASE_DEB[p], PHASE_LONG[p]);
      gaps_on  = (p != QUIET_PHASE);
      ph_ticks = accepted_ticks;
      ph_codes = emitted_codes;
      while (accepted_ticks - ph_ticks < MIN_TICKS || emitted_codes - ph_codes < MIN_CODES)
      begin
        if ($urandom_range(99) < 15) begin
          send_tick(kdlp_pkg::KEY_LEVELS_W'($urandom), ROW_MODEL, KC_UP);
        end else begin
          // press: target key is the first low bit, the others are noise
          k  = ($urandom_range(2) == 0) ? LAST_KEY : int'($urandom_range(LAST_KEY));
          lv = kdlp_pkg::KEY_LEVELS_W'($urandom);
          for (int j = 0; j < k; j++) lv[j] = 1'b1;
          lv[k] = 1'b0;
          send_tick(lv, ROW_MODEL, KC_UP);
          case ($urandom_range(2))
            0: hold_n = int'($urandom_range(debounce_reg));
            1: begin
              if (long_reg <= 400) hold_n = int'(long_reg) + int'($urandom_range(4)) - 2;
              else hold_n = int'(debounce_reg) + 5;
            end
            default: hold_n = int'(debounce_reg) + int'($urandom_range(20));
          endcase
          if (hold_n < 0) hold_n = 0;
          // hold, with bounce allowed only ahead of the re-sample
          for (int j = 0; j < hold_n; j++) begin
            lv    = kdlp_pkg::KEY_LEVELS_W'($urandom);
            lv[k] = (j + 1 < debounce_reg) && ($urandom_range(9) == 0);
            send_tick(lv, ROW_MODEL, KC_UP);
          end
          lv    = kdlp_pkg::KEY_LEVELS_W'($urandom);
          lv[k] = 1'b1;
          send_tick(lv, ROW_MODEL, KC_UP);
          repeat ($urandom_range(2)) send_tick(ALL_UP, ROW_MODEL, KC_UP);
        end
      end
    end

    gaps_on = 1'b1;
    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/kdlp_pkg.sv
src/kdlp_out_skid.sv
src/key_debounce_long_press.sv
dv/tb.sv
